FILE: src/cma_equalizer_two_by_two_defines.svh
// Assertion macros for the two-by-two CMA equalizer.
// Self-contained; included by the top level only.
`ifndef CMA_EQUALIZER_TWO_BY_TWO_DEFINES_SVH
`define CMA_EQUALIZER_TWO_BY_TWO_DEFINES_SVH

// same-cycle implication
`define CMAEQ_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CMAEQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/cmaeq_pkg.sv
// Shared types, register indexes and saturation helpers of the CMA equalizer.
// No dependencies.
package cmaeq_pkg;

	localparam int TAP_W = 18;
	localparam int ERR_W = 17;

	typedef enum logic [1:0] {
		REG_MODULUS   = 2'd0,
		REG_STEP_SIZE = 2'd1,
		REG_PASSES    = 2'd2,
		REG_DECIM     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                    shift;
		logic                    br;
		logic                    upd;
		logic signed [ERR_W-1:0] e_re;
		logic signed [ERR_W-1:0] e_im;
		logic [15:0]             mu;
	} cell_ctrl_t;

	typedef struct packed {
		logic                    done;
		logic signed [ERR_W-1:0] e_re;
		logic signed [ERR_W-1:0] e_im;
	} err_res_t;

	// round half up of p / 2^30, clip to [-32768, 32768]
	function automatic logic signed [ERR_W-1:0] err_clip(input logic signed [51:0] p);
		logic signed [51:0] t;
		logic signed [21:0] r;
		t = p + 52'sd536870912;
		r = t[51:30];
		if (r > 22'sd32768)
			return 17'sd32768;
		else if (r < -22'sd32768)
			return -17'sd32768;
		else
			return r[ERR_W-1:0];
	endfunction

	// tap minus rounded step term, saturated to the tap range
	function automatic logic signed [TAP_W-1:0] tap_upd(input logic signed [TAP_W-1:0] tap,
			input logic signed [50:0] m);
		logic signed [50:0] t;
		logic signed [20:0] d;
		logic signed [21:0] n;
		t = m + 51'sd536870912;
		d = t[50:30];
		n = 22'(tap) - 22'(d);
		if (n > 22'sd131071)
			return 18'sd131071;
		else if (n < -22'sd131072)
			return -18'sd131072;
		else
			return n[TAP_W-1:0];
	endfunction

endpackage

FILE: src/cmaeq_cell.sv
// One equalizer cell: a window entry, its two taps, its share of the dot product
// and its own tap update. Uses cmaeq_pkg.
module cmaeq_cell #(
	parameter int ACC_W  = 39,
	parameter bit T1_ONE = 1'b0,
	parameter bit T2_ONE = 1'b0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmaeq_pkg::cell_ctrl_t     ctrl,
	input  logic signed [15:0]        shin_re,
	input  logic signed [15:0]        shin_im,
	input  logic signed [ACC_W-1:0]   psin_re,
	input  logic signed [ACC_W-1:0]   psin_im,
	output logic signed [15:0]        win_re,
	output logic signed [15:0]        win_im,
	output logic signed [ACC_W-1:0]   psout_re,
	output logic signed [ACC_W-1:0]   psout_im
);

	localparam logic signed [17:0] ONE = 18'sd65536;

	logic signed [15:0] w_re_q, w_im_q;
	logic signed [17:0] t1_re_q, t1_im_q, t2_re_q, t2_im_q;
	logic signed [17:0] t_re, t_im;
	logic signed [34:0] prod_re_s1, prod_im_s1;
	logic signed [ACC_W-1:0] ps_re_q, ps_im_q;
	logic signed [33:0] pr_s1, pi_s1;
	logic signed [33:0] m_rr, m_ii, m_ri, m_ir;
	logic signed [33:0] u_rr, u_ii, u_ri, u_ir;
	logic signed [50:0] mu_x, d_re, d_im;
	logic signed [17:0] n_re, n_im;

	assign t_re = ctrl.br ? t2_re_q : t1_re_q;
	assign t_im = ctrl.br ? t2_im_q : t1_im_q;

	assign m_rr = 34'(w_re_q) * 34'(t_re);
	assign m_ii = 34'(w_im_q) * 34'(t_im);
	assign m_ri = 34'(w_re_q) * 34'(t_im);
	assign m_ir = 34'(w_im_q) * 34'(t_re);

	// conj(window) * error
	assign u_rr = 34'(w_re_q) * 34'(ctrl.e_re);
	assign u_ii = 34'(w_im_q) * 34'(ctrl.e_im);
	assign u_ri = 34'(w_re_q) * 34'(ctrl.e_im);
	assign u_ir = 34'(w_im_q) * 34'(ctrl.e_re);

	assign mu_x = $signed({35'd0, ctrl.mu});
	assign d_re = 51'(pr_s1) * mu_x;
	assign d_im = 51'(pi_s1) * mu_x;
	assign n_re = cmaeq_pkg::tap_upd(t_re, d_re);
	assign n_im = cmaeq_pkg::tap_upd(t_im, d_im);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_re_q  <= '0;
			w_im_q  <= '0;
			t1_re_q <= T1_ONE ? ONE : '0;
			t1_im_q <= '0;
			t2_re_q <= T2_ONE ? ONE : '0;
			t2_im_q <= '0;
		end else begin
			if (ctrl.shift) begin
				w_re_q <= shin_re;
				w_im_q <= shin_im;
			end
			if (ctrl.upd && !ctrl.br) begin
				t1_re_q <= n_re;
				t1_im_q <= n_im;
			end
			if (ctrl.upd && ctrl.br) begin
				t2_re_q <= n_re;
				t2_im_q <= n_im;
			end
		end
	end

	// partial sums ripple one cell per cycle
	always_ff @(posedge clk) begin
		prod_re_s1 <= 35'(m_rr) - 35'(m_ii);
		prod_im_s1 <= 35'(m_ri) + 35'(m_ir);
		ps_re_q    <= psin_re + ACC_W'(prod_re_s1);
		ps_im_q    <= psin_im + ACC_W'(prod_im_s1);
		pr_s1      <= u_rr + u_ii;
		pi_s1      <= u_ri - u_ir;
	end

	assign win_re   = w_re_q;
	assign win_im   = w_im_q;
	assign psout_re = ps_re_q;
	assign psout_im = ps_im_q;

endmodule

FILE: src/cmaeq_err.sv
// CMA error unit: e = y*(|y|^2 - R), three registered steps.
// Uses cmaeq_pkg.
module cmaeq_err (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [15:0]      y_re,
	input  logic signed [15:0]      y_im,
	input  logic [15:0]             modulus,
	output cmaeq_pkg::err_res_t     res
);

	logic v_s1, v_s2, v_s3;
	logic signed [15:0] y_re_s1, y_im_s1;
	logic signed [32:0] mag_s1;
	logic signed [35:0] diff;
	logic signed [51:0] p_re_s2, p_im_s2;
	logic signed [16:0] e_re_s3, e_im_s3;

	assign diff = 36'(mag_s1) - $signed({2'b00, modulus, 18'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_re_s1 <= y_re;
			y_im_s1 <= y_im;
			mag_s1  <= 33'(32'(y_re) * 32'(y_re)) + 33'(32'(y_im) * 32'(y_im));
		end
		p_re_s2 <= 52'(y_re_s1) * 52'(diff);
		p_im_s2 <= 52'(y_im_s1) * 52'(diff);
		e_re_s3 <= cmaeq_pkg::err_clip(p_re_s2);
		e_im_s3 <= cmaeq_pkg::err_clip(p_im_s2);
	end

	assign res.done = v_s3;
	assign res.e_re = e_re_s3;
	assign res.e_im = e_im_s3;

endmodule

FILE: src/cma_equalizer_two_by_two.sv
// Two-by-two CMA blind equalizer: control, configuration and the row of cells.
// Uses cmaeq_pkg, cmaeq_cell, cmaeq_err and cma_equalizer_two_by_two_defines.svh.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, a_re a_im b_re b_im   | in
//  output  | out_valid, out_stall, y1_re y1_im y2_*    | out
//  config  | psel penable pwrite paddr pwdata prdata   | APB
//
// A request that does not complete a decim group only shifts the window and counts.
// Completing a group runs passes rounds over both branches: the partial sum
// ripples through TAP_COUNT cells, then the error unit and a two-step update.
// No request is taken until the result of a group sits in the output register.
// A stalled result holds; reset restores unit-spike taps and an empty window.
`include "cma_equalizer_two_by_two_defines.svh"
module cma_equalizer_two_by_two #(
	parameter int TAP_COUNT = 10,
	parameter int HALF_TAPS = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] a_re,
	input  logic signed [15:0] a_im,
	input  logic signed [15:0] b_re,
	input  logic signed [15:0] b_im,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] y1_re,
	output logic signed [15:0] y1_im,
	output logic signed [15:0] y2_re,
	output logic signed [15:0] y2_im,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int ACC_W  = 35 + $clog2(TAP_COUNT);
	localparam int CNT_W  = $clog2(TAP_COUNT + 2);
	localparam int T1_IDX = ((TAP_COUNT - 2) / 4) % TAP_COUNT;
	localparam int T2_IDX = ((3 * TAP_COUNT - 2) / 4) % TAP_COUNT;
	localparam logic [CNT_W-1:0] FILT_LAST = CNT_W'(TAP_COUNT + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_FILT = 6'b000010,
		ST_ERR  = 6'b000100,
		ST_UPD1 = 6'b001000,
		ST_UPD2 = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic br_q;
	logic [3:0] pass_q, pc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0] modulus_q, step_q;
	logic [4:0] passes_q, decim_q;
	logic [4:0] passes_eff, decim_eff, pc_next;
	logic fire, last_pass, in_acc, out_acc, cfg_wr, err_start, can_load;
	logic signed [15:0] y1_re_q, y1_im_q, y2_re_q, y2_im_q;
	logic signed [15:0] ysat_re, ysat_im;
	logic signed [15:0] o1_re_q, o1_im_q, o2_re_q, o2_im_q;
	logic out_valid_q;
	cmaeq_pkg::cell_ctrl_t ctrl;
	cmaeq_pkg::err_res_t err;

	logic signed [15:0] win_re [TAP_COUNT];
	logic signed [15:0] win_im [TAP_COUNT];
	logic signed [15:0] shin_re [TAP_COUNT];
	logic signed [15:0] shin_im [TAP_COUNT];
	logic signed [ACC_W-1:0] ps_re [TAP_COUNT];
	logic signed [ACC_W-1:0] ps_im [TAP_COUNT];

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 16'd4096;
			step_q    <= 16'd66;
			passes_q  <= 5'd1;
			decim_q   <= 5'd2;
		end else if (cfg_wr) begin
			case (cmaeq_pkg::reg_idx_t'(paddr[3:2]))
				cmaeq_pkg::REG_MODULUS:   modulus_q <= pwdata[15:0];
				cmaeq_pkg::REG_STEP_SIZE: step_q    <= pwdata[15:0];
				cmaeq_pkg::REG_PASSES:    passes_q  <= pwdata[4:0];
				cmaeq_pkg::REG_DECIM:     decim_q   <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmaeq_pkg::reg_idx_t'(paddr[3:2]))
			cmaeq_pkg::REG_MODULUS:   prdata = {16'd0, modulus_q};
			cmaeq_pkg::REG_STEP_SIZE: prdata = {16'd0, step_q};
			cmaeq_pkg::REG_PASSES:    prdata = {27'd0, passes_q};
			cmaeq_pkg::REG_DECIM:     prdata = {27'd0, decim_q};
			default:                  prdata = '0;
		endcase
	end

	assign passes_eff = (passes_q == 5'd0) ? 5'd1 : ((passes_q > 5'd16) ? 5'd16 : passes_q);
	assign decim_eff  = (decim_q == 5'd0) ? 5'd1 : ((decim_q > 5'd16) ? 5'd16 : decim_q);
	assign pc_next    = {1'b0, pc_q} + 5'd1;
	assign fire       = pc_next >= decim_eff;
	assign last_pass  = ({1'b0, pass_q} == passes_eff - 5'd1);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign can_load = !out_valid_q || !out_stall;

	// dot product result, rounded and saturated
	always_comb begin
		logic signed [ACC_W-1:0] tr, ti;
		logic signed [ACC_W-17:0] sr, si;
		tr = ps_re[TAP_COUNT-1] + ACC_W'(32768);
		ti = ps_im[TAP_COUNT-1] + ACC_W'(32768);
		sr = tr[ACC_W-1:16];
		si = ti[ACC_W-1:16];
		if (sr > (ACC_W-16)'(32767))
			ysat_re = 16'sh7fff;
		else if (sr < -(ACC_W-16)'(32768))
			ysat_re = -16'sh8000;
		else
			ysat_re = sr[15:0];
		if (si > (ACC_W-16)'(32767))
			ysat_im = 16'sh7fff;
		else if (si < -(ACC_W-16)'(32768))
			ysat_im = -16'sh8000;
		else
			ysat_im = si[15:0];
	end

	assign err_start = (state_q == ST_FILT) && (cnt_q == FILT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			br_q        <= 1'b0;
			pass_q      <= '0;
			pc_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && can_load)
				out_valid_q <= 1'b1;
			else if (out_acc)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pc_q <= fire ? 4'd0 : pc_next[3:0];
						if (fire) begin
							state_q <= ST_FILT;
							br_q    <= 1'b0;
							pass_q  <= '0;
							cnt_q   <= '0;
						end
					end
				end
				ST_FILT: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (err_start)
						state_q <= ST_ERR;
				end
				ST_ERR: begin
					if (err.done)
						state_q <= ST_UPD1;
				end
				ST_UPD1: state_q <= ST_UPD2;
				ST_UPD2: begin
					cnt_q <= '0;
					if (!br_q) begin
						br_q    <= 1'b1;
						state_q <= ST_FILT;
					end else if (last_pass) begin
						state_q <= ST_OUT;
					end else begin
						br_q    <= 1'b0;
						pass_q  <= pass_q + 4'd1;
						state_q <= ST_FILT;
					end
				end
				ST_OUT: begin
					if (can_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (err_start && !br_q) begin
			y1_re_q <= ysat_re;
			y1_im_q <= ysat_im;
		end
		if (err_start && br_q) begin
			y2_re_q <= ysat_re;
			y2_im_q <= ysat_im;
		end
		if (state_q == ST_OUT && can_load) begin
			o1_re_q <= y1_re_q;
			o1_im_q <= y1_im_q;
			o2_re_q <= y2_re_q;
			o2_im_q <= y2_im_q;
		end
	end

	assign out_valid = out_valid_q;
	assign y1_re = o1_re_q;
	assign y1_im = o1_im_q;
	assign y2_re = o2_re_q;
	assign y2_im = o2_im_q;

	cmaeq_err u_err (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (err_start),
		.y_re    (ysat_re),
		.y_im    (ysat_im),
		.modulus (modulus_q),
		.res     (err)
	);

	assign ctrl.shift = in_acc;
	assign ctrl.br    = br_q;
	assign ctrl.upd   = (state_q == ST_UPD2);
	assign ctrl.e_re  = err.e_re;
	assign ctrl.e_im  = err.e_im;
	assign ctrl.mu    = step_q;

	for (genvar j = 0; j < TAP_COUNT; j++) begin : g_cells
		// window shift: each branch moves toward index 0, new sample at its top slot
		if (j < HALF_TAPS) begin : g_a
			if (j == HALF_TAPS - 1) begin : g_new
				assign shin_re[j] = a_re;
				assign shin_im[j] = a_im;
			end else if (j + 1 < TAP_COUNT) begin : g_mv
				assign shin_re[j] = win_re[(j + 1) % TAP_COUNT];
				assign shin_im[j] = win_im[(j + 1) % TAP_COUNT];
			end else begin : g_keep
				assign shin_re[j] = win_re[j];
				assign shin_im[j] = win_im[j];
			end
		end else if (j < 2 * HALF_TAPS) begin : g_b
			if (j == 2 * HALF_TAPS - 1) begin : g_new
				assign shin_re[j] = b_re;
				assign shin_im[j] = b_im;
			end else if (j + 1 < TAP_COUNT) begin : g_mv
				assign shin_re[j] = win_re[(j + 1) % TAP_COUNT];
				assign shin_im[j] = win_im[(j + 1) % TAP_COUNT];
			end else begin : g_keep
				assign shin_re[j] = win_re[j];
				assign shin_im[j] = win_im[j];
			end
		end else begin : g_none
			assign shin_re[j] = win_re[j];
			assign shin_im[j] = win_im[j];
		end

		logic signed [ACC_W-1:0] pin_re, pin_im;
		if (j == 0) begin : g_head
			assign pin_re = '0;
			assign pin_im = '0;
		end else begin : g_link
			assign pin_re = ps_re[(j + TAP_COUNT - 1) % TAP_COUNT];
			assign pin_im = ps_im[(j + TAP_COUNT - 1) % TAP_COUNT];
		end

		cmaeq_cell #(
			.ACC_W  (ACC_W),
			.T1_ONE (j == T1_IDX),
			.T2_ONE (j == T2_IDX)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.shin_re  (shin_re[j]),
			.shin_im  (shin_im[j]),
			.psin_re  (pin_re),
			.psin_im  (pin_im),
			.win_re   (win_re[j]),
			.win_im   (win_im[j]),
			.psout_re (ps_re[j]),
			.psout_im (ps_im[j])
		);
	end

	`CMAEQ_ASSERT_NOW(a_err_in_err, clk, arst_n, err.done, state_q == ST_ERR, "error result outside error phase")
	`CMAEQ_ASSERT_NEXT(a_second_branch, clk, arst_n, state_q == ST_UPD2 && !br_q, state_q == ST_FILT && br_q, "second branch not started after first update")
	`CMAEQ_ASSERT_NOW(a_pass_range, clk, arst_n, state_q == ST_FILT, {1'b0, pass_q} < passes_eff, "pass count beyond passes")

endmodule
